// ===== src/escaped_record_field_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escaped record field decoder
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_RECORD_FIELD_DECODER_MACROS_SVH
`define ESCAPED_RECORD_FIELD_DECODER_MACROS_SVH

// same-cycle implication
`define ERFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/erfd_pkg.sv =====
// ----------------------------------------------------------------------------
// erfd_pkg
// Types, constants and character classes of the escaped record field decoder.
// ----------------------------------------------------------------------------
package erfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LineW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [CountW-1:0] MaxLenReset = 16'h8000;
  localparam logic [LineW-1:0]  LineReset   = 32'd1;
  localparam logic [LineW-1:0]  LineMax     = 32'hFFFF_FFFF;

  localparam logic [ByteW-1:0] ChEscape = 8'h25;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;

  typedef enum logic [0:0] {
    REG_MAX_RECORD_LEN = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_EOI  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_REC  = 4'b0010,
    PH_ESC1 = 4'b0100,
    PH_ESC2 = 4'b1000
  } phase_e;

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_delim(input logic [ByteW-1:0] c);
    return (c == ChComma) || (c == ChLf) || (c == ChCr);
  endfunction

  function automatic logic is_conv_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_sign(input logic [ByteW-1:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  // base-16 conversion of two characters, low byte kept
  function automatic logic [ByteW-1:0] decode_escape(input logic [ByteW-1:0] a,
                                                     input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    logic             neg;
    v   = '0;
    neg = 1'b0;
    if (is_conv_space(a)) begin
      if (!is_conv_space(b) && !is_sign(b) && is_hex(b)) begin
        v = {4'h0, hex_val(b)};
      end
    end else if (is_sign(a)) begin
      neg = (a == ChMinus);
      if (is_hex(b)) begin
        v = {4'h0, hex_val(b)};
      end
    end else if (is_hex(a)) begin
      if (is_hex(b)) begin
        v = {hex_val(a), hex_val(b)};
      end else begin
        v = {4'h0, hex_val(a)};
      end
    end
    return neg ? (8'h00 - v) : v;
  endfunction

endpackage

// ===== src/erfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// erfd stream interfaces
// Valid/ready channels for text items in and decoded items out.
// ----------------------------------------------------------------------------
interface erfd_in_if
  import erfd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface erfd_out_if
  import erfd_pkg::*;
();
  logic             valid;
  logic             ready;
  kind_e            out_kind;
  logic [ByteW-1:0] data_byte;
  logic [LineW-1:0] start_line;

  modport source (output valid, output out_kind, output data_byte, output start_line,
                  input ready);
  modport sink   (input valid, input out_kind, input data_byte, input start_line,
                  output ready);
endinterface

// ===== src/erfd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// erfd_apb_regs
// APB-style register file holding the record length limit.
// ----------------------------------------------------------------------------
module erfd_apb_regs
  import erfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [CountW-1:0]   max_len_o
);

  logic [CountW-1:0] max_len_q, max_len_d;
  logic              sel_max;
  logic              wr_en;

  assign pready  = 1'b1;
  assign sel_max = (reg_idx_e'(paddr[CfgAddrW-1]) == REG_MAX_RECORD_LEN);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en && sel_max) begin
      max_len_d = pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata    = sel_max ? {{(CfgDataW-CountW){1'b0}}, max_len_q} : '0;
  assign max_len_o = max_len_q;

endmodule

// ===== src/escaped_record_field_decoder.sv =====
// ----------------------------------------------------------------------------
// escaped_record_field_decoder
// Splits a text byte stream into comma/CR/LF delimited records, decodes %XY
// escapes and reports the starting line of each record.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------
//   in_i     | in  | valid / ready    | in_byte, end_of_text
//   out_o    | out | valid / ready    | out_kind, data_byte, start_line
//   apb      | in  | psel / penable   | paddr, pwdata, prdata (pready = 1)
//
// One item per cycle sustained while out_o is not stalled.
// Input register feeds a state update into the result register.
// A stalled result holds the pipe only once the input register is full too.
// Reset returns to blank skipping, line 1, limit 0x8000; no clearing pass.
// ----------------------------------------------------------------------------
`include "escaped_record_field_decoder_macros.svh"

module escaped_record_field_decoder
  import erfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  erfd_in_if.sink             in_i,
  erfd_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [CountW-1:0] max_len;

  erfd_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_eot_q;
  logic             advance;
  logic             s1_fire;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  esc_q, esc_d;
  logic [LineW-1:0]  line_q, line_d;
  logic [LineW-1:0]  rec_line_q, rec_line_d;
  logic [CountW-1:0] count_q, count_d;

  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [ByteW-1:0] out_data_q;
  logic [LineW-1:0] out_line_q;

  logic             emit;
  kind_e            kind;
  logic [ByteW-1:0] data;
  logic [LineW-1:0] sline;

  assign advance    = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_eot_q  <= in_i.end_of_text;
    end
  end

  always_comb begin
    logic [LineW-1:0]  line_eff;
    logic [CountW-1:0] count_eff;
    logic              rec;
    phase_d    = phase_q;
    esc_d      = esc_q;
    line_d     = line_q;
    rec_line_d = rec_line_q;
    count_d    = count_q;
    emit       = 1'b0;
    kind       = KIND_DATA;
    data       = '0;
    sline      = '0;
    rec        = 1'b0;
    line_eff   = rec_line_q;
    count_eff  = count_q;
    case (phase_q)
      PH_SKIP: begin
        if (s1_eot_q) begin
          emit = 1'b1;
          kind = KIND_EOI;
        end else if (is_blank(s1_byte_q)) begin
          if ((s1_byte_q == ChLf) && (line_q != LineMax)) begin
            line_d = line_q + 1'b1;
          end
        end else begin
          rec        = 1'b1;
          rec_line_d = line_q;
          line_eff   = line_q;
          count_eff  = '0;
          count_d    = '0;
        end
      end
      PH_REC: begin
        rec = 1'b1;
      end
      PH_ESC1: begin
        if (s1_eot_q || is_delim(s1_byte_q)) begin
          emit    = 1'b1;
          kind    = KIND_ERR;
          phase_d = PH_SKIP;
        end else begin
          esc_d   = s1_byte_q;
          phase_d = PH_ESC2;
        end
      end
      PH_ESC2: begin
        if (s1_eot_q || is_delim(s1_byte_q)) begin
          emit    = 1'b1;
          kind    = KIND_ERR;
          phase_d = PH_SKIP;
        end else begin
          emit    = 1'b1;
          kind    = KIND_DATA;
          data    = decode_escape(esc_q, s1_byte_q);
          count_d = count_q + 1'b1;
          phase_d = PH_REC;
        end
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase

    if (rec) begin
      if (s1_eot_q || is_delim(s1_byte_q) || (count_eff >= max_len)) begin
        if (!s1_eot_q && (s1_byte_q == ChLf) && (line_q != LineMax)) begin
          line_d = line_q + 1'b1;
        end
        emit    = 1'b1;
        kind    = KIND_END;
        sline   = line_eff;
        phase_d = PH_SKIP;
      end else if (s1_byte_q == ChEscape) begin
        phase_d = PH_ESC1;
      end else begin
        emit    = 1'b1;
        kind    = KIND_DATA;
        data    = s1_byte_q;
        count_d = count_eff + 1'b1;
        phase_d = PH_REC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SKIP;
      esc_q      <= '0;
      line_q     <= LineReset;
      rec_line_q <= '0;
      count_q    <= '0;
    end else if (s1_fire) begin
      phase_q    <= phase_d;
      esc_q      <= esc_d;
      line_q     <= line_d;
      rec_line_q <= rec_line_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_kind_q <= kind;
      out_data_q <= data;
      out_line_q <= sline;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_kind   = out_kind_q;
  assign out_o.data_byte  = out_data_q;
  assign out_o.start_line = out_line_q;

  `ERFD_ASSERT_IMP(a_ready_when_out_free, !out_valid_q, in_i.ready,
                   "input stalled with free result register")
  `ERFD_ASSERT_NXT(a_line_monotonic, 1'b1, line_q >= $past(line_q),
                   "line counter went backwards")
  `ERFD_ASSERT_IMP(a_eoi_clean, out_valid_q && (out_kind_q == KIND_EOI),
                   (out_line_q == '0) && (out_data_q == '0),
                   "end of input carries payload")
  `ERFD_ASSERT_IMP(a_data_no_line, out_valid_q && (out_kind_q == KIND_DATA),
                   out_line_q == '0, "data item carries a start line")

endmodule
